@@ hdl/dsrch_pkg.sv @@
// Shared types and constants for the directory entry search block.
package dsrch_pkg;

	localparam int unsigned MAX_SECTORS_PER_CLUSTER = 128;
	localparam int unsigned SLOTS_PER_SECTOR = 16;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam int unsigned APB_DATA_W = 64;
	localparam int unsigned APB_ADDR_W = 5;

	localparam logic [1:0] REG_NAME_HEAD = 2'd0;
	localparam logic [1:0] REG_NAME_TAIL = 2'd1;
	localparam logic [1:0] REG_MODE = 2'd2;

	localparam logic [1:0] ACT_BEGIN = 2'd0;
	localparam logic [1:0] ACT_ENTRY = 2'd1;
	localparam logic [1:0] ACT_END = 2'd2;

	localparam logic [1:0] ST_FOUND = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FREE = 2'd2;
	localparam logic [1:0] ST_EXTEND = 2'd3;

	localparam logic [27:0] CLUSTER_FIRST = 28'h0000002;
	localparam logic [27:0] CHAIN_END = 28'hFFFFFF8;
	localparam logic [7:0] MARK_END = 8'h00;
	localparam logic [7:0] MARK_DELETED = 8'hE5;
	localparam logic [7:0] ATTR_LONG = 8'h0F;
	localparam int unsigned ATTR_DIR_BIT = 4;

	typedef struct packed {
		logic [1:0] action;
		logic [63:0] name_head;
		logic [23:0] name_tail;
		logic [7:0] attr;
		logic [31:0] start_cluster;
		logic [31:0] size_bytes;
		logic [27:0] entry_cluster;
		logic [6:0] sector_index;
		logic [3:0] slot_index;
	} in_word_t;

	typedef struct packed {
		logic [1:0] status;
		logic [27:0] dir_cluster;
		logic [15:0] byte_offset;
		logic [7:0] found_attr;
		logic [31:0] found_first_cluster;
		logic [31:0] found_size;
		logic found_is_dir;
	} out_word_t;

	typedef struct packed {
		logic [63:0] name_head;
		logic [23:0] name_tail;
		logic mode;
	} cfg_t;

endpackage

@@ hdl/dsrch_front.sv @@
// Front end: takes entries, tracks the search state and forms result words.
module dsrch_front (
	input logic clk,
	input logic arst_n,
	input logic take,
	input dsrch_pkg::in_word_t in_word,
	input dsrch_pkg::cfg_t cfg,
	output logic push,
	output dsrch_pkg::out_word_t push_word
);

	logic done_q;
	logic [27:0] last_q;
	logic done_d;
	logic [27:0] last_d;
	logic emit;
	logic ecl_ok;
	logic pos_ok;
	logic name_match;
	logic [7:0] b0;
	logic [15:0] offset;

	assign b0 = in_word.name_head[7:0];
	assign ecl_ok = (in_word.entry_cluster >= dsrch_pkg::CLUSTER_FIRST) &&
		(in_word.entry_cluster < dsrch_pkg::CHAIN_END);
	assign pos_ok = ({1'b0, in_word.sector_index} < 8'(dsrch_pkg::MAX_SECTORS_PER_CLUSTER)) &&
		({1'b0, in_word.slot_index} < 5'(dsrch_pkg::SLOTS_PER_SECTOR));
	assign name_match = (in_word.name_head == cfg.name_head) &&
		(in_word.name_tail == cfg.name_tail);
	assign offset = {in_word.sector_index, in_word.slot_index, 5'b00000};

	always_comb begin
		emit = 1'b0;
		push_word = '0;
		done_d = done_q;
		last_d = last_q;
		unique case (in_word.action)
			dsrch_pkg::ACT_BEGIN: begin
				done_d = 1'b0;
				last_d = '0;
			end
			dsrch_pkg::ACT_END: begin
				if (!done_q) begin
					emit = 1'b1;
					if (cfg.mode) begin
						push_word.status = dsrch_pkg::ST_EXTEND;
						push_word.dir_cluster = last_q;
					end else begin
						push_word.status = dsrch_pkg::ST_NOT_FOUND;
					end
				end
			end
			dsrch_pkg::ACT_ENTRY: begin
				if (!done_q && ecl_ok) begin
					last_d = in_word.entry_cluster;
					if (pos_ok) begin
						if (cfg.mode) begin
							if (b0 == dsrch_pkg::MARK_END || b0 == dsrch_pkg::MARK_DELETED) begin
								emit = 1'b1;
								push_word.status = dsrch_pkg::ST_FREE;
								push_word.dir_cluster = in_word.entry_cluster;
								push_word.byte_offset = offset;
							end
						end else if (b0 == dsrch_pkg::MARK_END) begin
							emit = 1'b1;
							push_word.status = dsrch_pkg::ST_NOT_FOUND;
						end else if (b0 != dsrch_pkg::MARK_DELETED &&
							in_word.attr != dsrch_pkg::ATTR_LONG && name_match) begin
							emit = 1'b1;
							push_word.status = dsrch_pkg::ST_FOUND;
							push_word.dir_cluster = in_word.entry_cluster;
							push_word.byte_offset = offset;
							push_word.found_attr = in_word.attr;
							push_word.found_first_cluster = in_word.start_cluster;
							push_word.found_size = in_word.size_bytes;
							push_word.found_is_dir = in_word.attr[dsrch_pkg::ATTR_DIR_BIT];
						end
					end
				end
			end
			default: begin
			end
		endcase
		if (emit) begin
			done_d = 1'b1;
		end
	end

	assign push = take && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b1;
			last_q <= '0;
		end else if (take) begin
			done_q <= done_d;
			last_q <= last_d;
		end
	end

endmodule

@@ hdl/dsrch_queue.sv @@
// Short result queue between the front end and the output stage.
module dsrch_queue #(
	parameter int unsigned DEPTH = dsrch_pkg::QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input dsrch_pkg::out_word_t push_word,
	input logic pop,
	output logic full,
	output logic nonempty,
	output dsrch_pkg::out_word_t head_word
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	dsrch_pkg::out_word_t slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_W'(DEPTH));
	assign nonempty = (count_q != '0);
	assign head_word = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hdl/dsrch_out.sv @@
// Output stage: holds one result word until the consumer takes it.
module dsrch_out (
	input logic clk,
	input logic arst_n,
	input logic q_nonempty,
	input dsrch_pkg::out_word_t q_word,
	output logic pop,
	input logic out_stall,
	output logic out_valid,
	output dsrch_pkg::out_word_t out_word
);

	logic valid_q;
	dsrch_pkg::out_word_t word_q;

	assign pop = q_nonempty && (!valid_q || !out_stall);
	assign out_valid = valid_q;
	assign out_word = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || !out_stall) begin
			valid_q <= q_nonempty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			word_q <= q_word;
		end
	end

endmodule

@@ hdl/directory_entry_search_top.sv @@
// Top level of the directory entry search block with its register port.
// Throughput is one word per cycle; the input stalls only while the result queue is full.
// A result word is written into the queue at the edge that accepts its input word, and
// out_valid rises when the output register, once empty or not stalled, loads it.
// Reset ends any search, clears the last cluster seen, the registers and the queue.
module directory_entry_search_top #(
	parameter int unsigned QUEUE_DEPTH = dsrch_pkg::QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [dsrch_pkg::APB_ADDR_W-1:0] paddr,
	input logic [dsrch_pkg::APB_DATA_W-1:0] pwdata,
	output logic [dsrch_pkg::APB_DATA_W-1:0] prdata,
	output logic pready,
	input logic in_valid,
	output logic in_stall,
	input dsrch_pkg::in_word_t in_word,
	output logic out_valid,
	input logic out_stall,
	output dsrch_pkg::out_word_t out_word
);

	dsrch_pkg::cfg_t cfg_q;
	logic wr_en;
	logic take;
	logic push;
	logic pop;
	logic q_full;
	logic q_nonempty;
	dsrch_pkg::out_word_t push_word;
	dsrch_pkg::out_word_t q_word;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (paddr[4:3])
				dsrch_pkg::REG_NAME_HEAD: cfg_q.name_head <= pwdata;
				dsrch_pkg::REG_NAME_TAIL: cfg_q.name_tail <= pwdata[23:0];
				dsrch_pkg::REG_MODE: cfg_q.mode <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:3])
			dsrch_pkg::REG_NAME_HEAD: prdata = cfg_q.name_head;
			dsrch_pkg::REG_NAME_TAIL: prdata = {40'd0, cfg_q.name_tail};
			dsrch_pkg::REG_MODE: prdata = {63'd0, cfg_q.mode};
			default: prdata = '0;
		endcase
	end

	assign in_stall = q_full;
	assign take = in_valid && !in_stall;

	dsrch_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.in_word(in_word),
		.cfg(cfg_q),
		.push(push),
		.push_word(push_word)
	);

	dsrch_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_word(push_word),
		.pop(pop),
		.full(q_full),
		.nonempty(q_nonempty),
		.head_word(q_word)
	);

	dsrch_out u_out (
		.clk(clk),
		.arst_n(arst_n),
		.q_nonempty(q_nonempty),
		.q_word(q_word),
		.pop(pop),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.out_word(out_word)
	);

endmodule

@@ hdl/dsrch_checker.sv @@
// Port-level checks on the directory entry search block, bound to its top level.
module dsrch_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input dsrch_pkg::out_word_t out_word
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("result word changed while stalled");

	a_dir_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.status == dsrch_pkg::ST_FOUND |->
		out_word.found_is_dir == out_word.found_attr[dsrch_pkg::ATTR_DIR_BIT])
		else $error("directory flag disagrees with attribute");

	a_no_match_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.status != dsrch_pkg::ST_FOUND |->
		out_word.found_attr == '0 && out_word.found_first_cluster == '0 &&
		out_word.found_size == '0 && !out_word.found_is_dir)
		else $error("entry fields set without a name match");

	a_no_offset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_word.status == dsrch_pkg::ST_NOT_FOUND ||
		out_word.status == dsrch_pkg::ST_EXTEND) |-> out_word.byte_offset == '0)
		else $error("offset set without a located entry");

	a_not_found_cluster: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.status == dsrch_pkg::ST_NOT_FOUND |->
		out_word.dir_cluster == '0)
		else $error("cluster set on a not found result");

endmodule

bind directory_entry_search_top dsrch_checker u_dsrch_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_word(out_word)
);

@@ bench/tb_directory_entry_search_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the directory entry search block: directed table, then random searches.
module tb_directory_entry_search_top;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned WORDS_PER_PHASE = 325;
	localparam int unsigned SETTLE_CYCLES = 4;

	typedef struct {
		bit is_cfg;
		logic [1:0] reg_idx;
		logic [63:0] data;
		dsrch_pkg::in_word_t w;
		bit typed;
		bit typed_has;
		dsrch_pkg::out_word_t typed_res;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [dsrch_pkg::APB_ADDR_W-1:0] paddr;
	logic [dsrch_pkg::APB_DATA_W-1:0] pwdata;
	logic [dsrch_pkg::APB_DATA_W-1:0] prdata;
	logic pready;
	logic in_valid;
	logic in_stall;
	dsrch_pkg::in_word_t in_word;
	logic out_valid;
	logic out_stall;
	dsrch_pkg::out_word_t out_word;

	logic [63:0] tgt_head = '0;
	logic [23:0] tgt_tail = '0;
	bit free_mode = 1'b0;
	bit search_idle = 1'b1;
	logic [27:0] last_dir_cluster = '0;

	dsrch_pkg::out_word_t pending_results[$];
	dir_row_t dir_rows[$];
	bit drv_typed = 1'b0;
	bit drv_typed_has = 1'b0;
	dsrch_pkg::out_word_t drv_typed_res = '0;
	dsrch_pkg::out_word_t predicted;
	bit predicted_has;

	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;
	bit hold_req = 1'b0;
	int holds_done = 0;
	int fail_count = 0;
	int words_sent = 0;
	int regs_written = 0;
	int status_seen[4] = '{0, 0, 0, 0};
	int unsigned cycle_count;

	directory_entry_search_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word(out_word)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_directory_entry_search_top failed");
		$finish;
	end

	function automatic bit dir_search_step(input dsrch_pkg::in_word_t w,
			output dsrch_pkg::out_word_t res);
		logic [15:0] offs;
		logic [7:0] b0;
		res = '0;
		b0 = w.name_head[7:0];
		if (w.action == dsrch_pkg::ACT_BEGIN) begin
			search_idle = 1'b0;
			last_dir_cluster = '0;
			return 1'b0;
		end
		if (w.action == ACT_UNUSED || search_idle)
			return 1'b0;
		if (w.action == dsrch_pkg::ACT_END) begin
			search_idle = 1'b1;
			if (free_mode) begin
				res.status = dsrch_pkg::ST_EXTEND;
				res.dir_cluster = last_dir_cluster;
			end else begin
				res.status = dsrch_pkg::ST_NOT_FOUND;
			end
			return 1'b1;
		end
		if (w.entry_cluster < dsrch_pkg::CLUSTER_FIRST || w.entry_cluster >= dsrch_pkg::CHAIN_END)
			return 1'b0;
		last_dir_cluster = w.entry_cluster;
		if (w.sector_index >= dsrch_pkg::MAX_SECTORS_PER_CLUSTER ||
			w.slot_index >= dsrch_pkg::SLOTS_PER_SECTOR)
			return 1'b0;
		offs = {w.sector_index, 9'd0} + {7'd0, w.slot_index, 5'd0};
		if (free_mode) begin
			if (b0 == dsrch_pkg::MARK_END || b0 == dsrch_pkg::MARK_DELETED) begin
				search_idle = 1'b1;
				res.status = dsrch_pkg::ST_FREE;
				res.dir_cluster = w.entry_cluster;
				res.byte_offset = offs;
				return 1'b1;
			end
			return 1'b0;
		end
		if (b0 == dsrch_pkg::MARK_END) begin
			search_idle = 1'b1;
			res.status = dsrch_pkg::ST_NOT_FOUND;
			return 1'b1;
		end
		if (b0 == dsrch_pkg::MARK_DELETED || w.attr == dsrch_pkg::ATTR_LONG)
			return 1'b0;
		if (w.name_head == tgt_head && w.name_tail == tgt_tail) begin
			search_idle = 1'b1;
			res.status = dsrch_pkg::ST_FOUND;
			res.dir_cluster = w.entry_cluster;
			res.byte_offset = offs;
			res.found_attr = w.attr;
			res.found_first_cluster = w.start_cluster;
			res.found_size = w.size_bytes;
			res.found_is_dir = w.attr[dsrch_pkg::ATTR_DIR_BIT];
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic check_result(input dsrch_pkg::out_word_t got);
		dsrch_pkg::out_word_t want;
		if (pending_results.size() == 0) begin
			$error("result word with nothing expected: status %0d, cluster %0h",
				got.status, got.dir_cluster);
			fail_count++;
			return;
		end
		want = pending_results.pop_front();
		if (got.status !== want.status) begin
			$error("status: expected %0d, got %0d", want.status, got.status);
			fail_count++;
		end
		if (got.dir_cluster !== want.dir_cluster) begin
			$error("dir_cluster: expected %0h, got %0h", want.dir_cluster, got.dir_cluster);
			fail_count++;
		end
		if (got.byte_offset !== want.byte_offset) begin
			$error("byte_offset: expected %0h, got %0h", want.byte_offset, got.byte_offset);
			fail_count++;
		end
		if (got.found_attr !== want.found_attr) begin
			$error("found_attr: expected %0h, got %0h", want.found_attr, got.found_attr);
			fail_count++;
		end
		if (got.found_first_cluster !== want.found_first_cluster) begin
			$error("found_first_cluster: expected %0h, got %0h",
				want.found_first_cluster, got.found_first_cluster);
			fail_count++;
		end
		if (got.found_size !== want.found_size) begin
			$error("found_size: expected %0h, got %0h", want.found_size, got.found_size);
			fail_count++;
		end
		if (got.found_is_dir !== want.found_is_dir) begin
			$error("found_is_dir: expected %0b, got %0b", want.found_is_dir, got.found_is_dir);
			fail_count++;
		end
		if (!$isunknown(got.status))
			status_seen[got.status]++;
	endtask

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			predicted_has = dir_search_step(in_word, predicted);
			if (drv_typed) begin
				predicted_has = drv_typed_has;
				predicted = drv_typed_res;
			end
			if (predicted_has)
				pending_results.push_back(predicted);
		end
		if (arst_n && out_valid && !out_stall)
			check_result(out_word);
	end

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
				holds_done++;
			end
			out_stall = ($urandom_range(0, 99) < rcv_idle_pct);
		end
	end

	task automatic send_word(input dsrch_pkg::in_word_t w);
		int gap;
		if (snd_idle_pct != 0 && $urandom_range(0, 99) < snd_idle_pct) begin
			in_valid = 1'b0;
			gap = $urandom_range(1, 4);
			repeat (gap) @(negedge clk);
		end
		in_word = w;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		in_valid = 1'b0;
		if (w.action != ACT_UNUSED)
			words_sent++;
	endtask

	task automatic apb_cycle(input bit wr, input logic [1:0] idx, input logic [63:0] data,
			output logic [63:0] rdata);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = wr;
		paddr = {idx, 3'b000};
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
		logic [63:0] mask;
		logic [63:0] rd_val;
		apb_cycle(1'b1, idx, data, rd_val);
		regs_written++;
		case (idx)
			dsrch_pkg::REG_NAME_HEAD: begin
				tgt_head = data;
				mask = '1;
			end
			dsrch_pkg::REG_NAME_TAIL: begin
				tgt_tail = data[23:0];
				mask = 64'hFF_FFFF;
			end
			default: begin
				free_mode = data[0];
				mask = 64'h1;
			end
		endcase
		apb_cycle(1'b0, idx, '0, rd_val);
		if ((rd_val & mask) !== (data & mask)) begin
			$error("register %0d read back: expected %0h, got %0h", idx, data & mask,
				rd_val & mask);
			fail_count++;
		end
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic dsrch_pkg::in_word_t rand_word();
		dsrch_pkg::in_word_t w;
		w.action = 2'($urandom);
		w.name_head = {$urandom, $urandom};
		w.name_tail = 24'($urandom);
		w.attr = 8'($urandom);
		w.start_cluster = $urandom;
		w.size_bytes = $urandom;
		w.entry_cluster = 28'($urandom);
		w.sector_index = 7'($urandom);
		w.slot_index = 4'($urandom);
		return w;
	endfunction

	function automatic dsrch_pkg::in_word_t rand_entry(input logic [27:0] cl,
			input logic [6:0] sec, input logic [3:0] slot);
		dsrch_pkg::in_word_t w;
		logic [87:0] nm;
		int r;
		w = rand_word();
		w.action = dsrch_pkg::ACT_ENTRY;
		w.entry_cluster = cl;
		w.sector_index = sec;
		w.slot_index = slot;
		r = $urandom_range(0, 99);
		if (r < 6) begin
			w.name_head[7:0] = dsrch_pkg::MARK_END;
		end else if (r < 18) begin
			w.name_head[7:0] = dsrch_pkg::MARK_DELETED;
		end else if (r < 28) begin
			w.name_head = tgt_head;
			w.name_tail = tgt_tail;
			w.attr = dsrch_pkg::ATTR_LONG;
		end else if (r < 42) begin
			w.name_head = tgt_head;
			w.name_tail = tgt_tail;
		end else if (r < 50) begin
			nm = {tgt_tail, tgt_head} ^ (88'd1 << $urandom_range(0, 87));
			w.name_tail = nm[87:64];
			w.name_head = nm[63:0];
		end
		r = $urandom_range(0, 99);
		if (r < 4)
			w.entry_cluster = 28'($urandom_range(0, 1));
		else if (r < 8)
			w.entry_cluster = 28'(dsrch_pkg::CHAIN_END + $urandom_range(0, 7));
		else if (r < 11)
			w.entry_cluster = 28'($urandom);
		return w;
	endfunction

	task automatic run_directory();
		dsrch_pkg::in_word_t w;
		logic [27:0] cl;
		logic [6:0] sec;
		logic [3:0] slot;
		int n;
		w = rand_word();
		w.action = dsrch_pkg::ACT_BEGIN;
		send_word(w);
		n = $urandom_range(1, 12);
		if ($urandom_range(0, 3) == 0)
			cl = 28'($urandom_range(2, 40));
		else
			cl = 28'($urandom_range(2, 32'h0FFF_FFF7));
		sec = 7'($urandom);
		slot = 4'($urandom);
		for (int k = 0; k < n; k++) begin
			send_word(rand_entry(cl, sec, slot));
			slot++;
			if (slot == 0)
				sec++;
			if ($urandom_range(0, 5) == 0) begin
				cl = 28'($urandom_range(2, 32'h0FFF_FFF7));
				sec = 0;
				slot = 0;
			end
		end
		if ($urandom_range(0, 3) != 0) begin
			w = rand_word();
			w.action = dsrch_pkg::ACT_END;
			send_word(w);
		end
	endtask

	function automatic dsrch_pkg::in_word_t mk_ctl(input logic [1:0] act);
		dsrch_pkg::in_word_t w;
		w = '0;
		w.action = act;
		return w;
	endfunction

	function automatic dsrch_pkg::in_word_t mk_entry(input logic [63:0] head,
			input logic [23:0] tail, input logic [7:0] attr, input logic [31:0] first,
			input logic [31:0] size, input logic [27:0] cl, input logic [6:0] sec,
			input logic [3:0] slot);
		dsrch_pkg::in_word_t w;
		w.action = dsrch_pkg::ACT_ENTRY;
		w.name_head = head;
		w.name_tail = tail;
		w.attr = attr;
		w.start_cluster = first;
		w.size_bytes = size;
		w.entry_cluster = cl;
		w.sector_index = sec;
		w.slot_index = slot;
		return w;
	endfunction

	function automatic dsrch_pkg::out_word_t mk_res(input logic [1:0] st, input logic [27:0] cl,
			input logic [15:0] offs, input logic [7:0] attr, input logic [31:0] first,
			input logic [31:0] size, input logic is_dir);
		dsrch_pkg::out_word_t r;
		r.status = st;
		r.dir_cluster = cl;
		r.byte_offset = offs;
		r.found_attr = attr;
		r.found_first_cluster = first;
		r.found_size = size;
		r.found_is_dir = is_dir;
		return r;
	endfunction

	function automatic dir_row_t wrow(input dsrch_pkg::in_word_t w);
		dir_row_t row;
		row = '{1'b0, 2'd0, 64'd0, w, 1'b0, 1'b0, '0};
		return row;
	endfunction

	function automatic dir_row_t trow(input dsrch_pkg::in_word_t w, input bit has,
			input dsrch_pkg::out_word_t res);
		dir_row_t row;
		row = '{1'b0, 2'd0, 64'd0, w, 1'b1, has, res};
		return row;
	endfunction

	function automatic dir_row_t crow(input logic [1:0] idx, input logic [63:0] data);
		dir_row_t row;
		row = '{1'b1, idx, data, '0, 1'b0, 1'b0, '0};
		return row;
	endfunction

	initial begin
		logic [63:0] nm_head;
		logic [23:0] nm_tail;
		logic [63:0] del_head;
		int phase_start;
		nm_head = 64'h2020_454D_4441_4552;
		nm_tail = 24'h54_58_54;
		del_head = {nm_head[63:8], dsrch_pkg::MARK_DELETED};
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		in_word = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		dir_rows.push_back(trow(mk_entry(nm_head, nm_tail, 8'h20, 32'd7, 32'd9, 28'd5, 7'd0, 4'd0),
			1'b0, '0));
		dir_rows.push_back(trow(mk_ctl(dsrch_pkg::ACT_END), 1'b0, '0));
		dir_rows.push_back(trow(mk_ctl(ACT_UNUSED), 1'b0, '0));
		dir_rows.push_back(crow(dsrch_pkg::REG_NAME_HEAD, nm_head));
		dir_rows.push_back(crow(dsrch_pkg::REG_NAME_TAIL, {40'd0, nm_tail}));
		dir_rows.push_back(crow(dsrch_pkg::REG_MODE, 64'd0));
		dir_rows.push_back(trow(mk_ctl(dsrch_pkg::ACT_BEGIN), 1'b0, '0));
		dir_rows.push_back(trow(mk_entry(nm_head, nm_tail, 8'h20, 32'd7, 32'd9, 28'd1, 7'd0, 4'd0),
			1'b0, '0));
		dir_rows.push_back(trow(mk_entry(nm_head, nm_tail, 8'h20, 32'd7, 32'd9,
			dsrch_pkg::CHAIN_END, 7'd0, 4'd0), 1'b0, '0));
		dir_rows.push_back(wrow(mk_entry(del_head, nm_tail, 8'h20, 32'd7, 32'd9, 28'd4,
			7'd3, 4'd1)));
		dir_rows.push_back(wrow(mk_entry(nm_head, nm_tail, dsrch_pkg::ATTR_LONG, 32'd7, 32'd9,
			28'd4, 7'd3, 4'd2)));
		dir_rows.push_back(trow(mk_entry(nm_head, nm_tail, 8'h10, '1, '1, 28'hFFF_FFF7,
			7'd127, 4'd15), 1'b1, mk_res(dsrch_pkg::ST_FOUND, 28'hFFF_FFF7, 16'hFFE0, 8'h10,
			'1, '1, 1'b1)));
		dir_rows.push_back(trow(mk_ctl(dsrch_pkg::ACT_END), 1'b0, '0));
		dir_rows.push_back(trow(mk_ctl(dsrch_pkg::ACT_BEGIN), 1'b0, '0));
		dir_rows.push_back(trow(mk_entry(64'd0, 24'd0, 8'h00, 32'd0, 32'd0, 28'hFFF_FFF7,
			7'd5, 4'd5), 1'b1, mk_res(dsrch_pkg::ST_NOT_FOUND, '0, '0, '0, '0, '0, 1'b0)));
		dir_rows.push_back(trow(mk_ctl(dsrch_pkg::ACT_BEGIN), 1'b0, '0));
		dir_rows.push_back(trow(mk_ctl(dsrch_pkg::ACT_END), 1'b1,
			mk_res(dsrch_pkg::ST_NOT_FOUND, '0, '0, '0, '0, '0, 1'b0)));
		dir_rows.push_back(trow(mk_ctl(dsrch_pkg::ACT_BEGIN), 1'b0, '0));
		dir_rows.push_back(trow(mk_ctl(dsrch_pkg::ACT_BEGIN), 1'b0, '0));
		dir_rows.push_back(trow(mk_entry(nm_head, nm_tail, 8'h00, 32'd0, 32'd0, 28'd2,
			7'd0, 4'd0), 1'b1, mk_res(dsrch_pkg::ST_FOUND, 28'd2, '0, '0, '0, '0, 1'b0)));
		dir_rows.push_back(crow(dsrch_pkg::REG_MODE, 64'd1));
		dir_rows.push_back(trow(mk_ctl(dsrch_pkg::ACT_BEGIN), 1'b0, '0));
		dir_rows.push_back(trow(mk_ctl(dsrch_pkg::ACT_END), 1'b1,
			mk_res(dsrch_pkg::ST_EXTEND, '0, '0, '0, '0, '0, 1'b0)));
		dir_rows.push_back(trow(mk_ctl(dsrch_pkg::ACT_BEGIN), 1'b0, '0));
		dir_rows.push_back(wrow(mk_entry(nm_head, nm_tail, 8'h20, 32'd7, 32'd9, 28'hFFF_FFF7,
			7'd0, 4'd0)));
		dir_rows.push_back(trow(mk_entry(del_head, nm_tail, 8'h20, 32'd7, 32'd9, 28'd3,
			7'd1, 4'd2), 1'b1, mk_res(dsrch_pkg::ST_FREE, 28'd3, 16'h0240, '0, '0, '0, 1'b0)));
		dir_rows.push_back(trow(mk_ctl(dsrch_pkg::ACT_BEGIN), 1'b0, '0));
		dir_rows.push_back(wrow(mk_entry(64'h41, nm_tail, 8'h20, 32'd7, 32'd9, 28'd9,
			7'd0, 4'd0)));
		dir_rows.push_back(trow(mk_ctl(dsrch_pkg::ACT_END), 1'b1,
			mk_res(dsrch_pkg::ST_EXTEND, 28'd9, '0, '0, '0, '0, 1'b0)));

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				drain();
				write_reg(dir_rows[i].reg_idx, dir_rows[i].data);
			end else begin
				drv_typed = dir_rows[i].typed;
				drv_typed_has = dir_rows[i].typed_has;
				drv_typed_res = dir_rows[i].typed_res;
				send_word(dir_rows[i].w);
				drv_typed = 1'b0;
			end
		end

		for (int phase = 0; phase < 6; phase++) begin
			drain();
			case (phase)
				0, 1: begin
					snd_idle_pct = 34;
					rcv_idle_pct = 78;
				end
				2, 3: begin
					snd_idle_pct = 78;
					rcv_idle_pct = 34;
				end
				default: begin
					snd_idle_pct = 0;
					rcv_idle_pct = 0;
				end
			endcase
			case (phase)
				0: begin
					write_reg(dsrch_pkg::REG_NAME_HEAD, '1);
					write_reg(dsrch_pkg::REG_NAME_TAIL, 64'hFF_FFFF);
				end
				1: begin
					write_reg(dsrch_pkg::REG_NAME_HEAD, '0);
					write_reg(dsrch_pkg::REG_NAME_TAIL, '0);
				end
				default: begin
					write_reg(dsrch_pkg::REG_NAME_HEAD, {$urandom, $urandom});
					write_reg(dsrch_pkg::REG_NAME_TAIL, {40'd0, 24'($urandom)});
				end
			endcase
			write_reg(dsrch_pkg::REG_MODE, {63'd0, (phase == 1 || phase == 3 || phase == 4)});
			if (phase == 4)
				hold_req = 1'b1;
			phase_start = words_sent;
			while (words_sent - phase_start < WORDS_PER_PHASE) begin
				if ($urandom_range(0, 9) == 0)
					send_word(rand_word());
				else
					run_directory();
			end
		end

		drain();
		$display("Run covered %0d input words, %0d register writes and %0d long output hold-off(s).",
			words_sent, regs_written, holds_done);
		$display("Results checked: %0d found, %0d not found, %0d free slot, %0d extend.",
			status_seen[dsrch_pkg::ST_FOUND], status_seen[dsrch_pkg::ST_NOT_FOUND],
			status_seen[dsrch_pkg::ST_FREE], status_seen[dsrch_pkg::ST_EXTEND]);
		if (fail_count == 0)
			$display("tb_directory_entry_search_top passed");
		else
			$display("tb_directory_entry_search_top failed");
		$finish;
	end

endmodule
